// ===== rtl/vrwr_pkg.sv =====
// Shared types, widths and codes for the virtual rate wait/release unit.
package vrwr_pkg;

   localparam int REG_W      = 14;
   localparam int HANDLES_W  = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int MASK_W     = 8;
   localparam int PHASE_W    = 13;
   localparam int RATE_W     = 22;
   localparam int PROD_W     = REG_W + HANDLES_W + 1;
   localparam int SLOTS      = 8;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CSR_IDX_W  = 1;
   localparam int DIV_STEPS  = REG_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [REG_W-1:0] BASE_RESET = REG_W'(1024);
   localparam logic [REG_W-1:0] MAX_RESET  = REG_W'(1024);
   localparam logic [REG_W-1:0] RATE_MIN   = REG_W'(2);
   localparam logic [REG_W-1:0] RATE_LIMIT = REG_W'(8192);

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE  = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_RATE = 2'd2
   } status_type;

   typedef enum logic {
      KIND_WAIT = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [REG_W-1:0]       rate_hz;
      logic [HANDLES_W-1:0]   open_handles;
   } req_item_type;

   typedef struct packed {
      status_type             status;
      logic [SLOT_OUT_W-1:0]  slot_index;
      logic [MASK_W-1:0]      released_mask;
   } rsp_item_type;

   typedef struct packed {
      logic [REG_W-1:0] base_rate_hz;
      logic [REG_W-1:0] max_rate_hz;
   } cfg_type;

endpackage

// ===== rtl/vrwr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module vrwr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vrwr_pkg::REG_W-1:0]  dividend,
   input  logic [vrwr_pkg::RATE_W-1:0] divisor,
   output logic                        busy,
   output logic                        done,
   output logic [vrwr_pkg::REG_W-1:0]  quotient,
   output logic [vrwr_pkg::REG_W-1:0]  remainder
);
   import vrwr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REG_W-1:0]     quo_ff, quo_in;
   logic [REG_W-1:0]     rem_ff, rem_in;
   logic [RATE_W-1:0]    dsr_ff, dsr_in;
   logic [REG_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[REG_W-1]};
      fits    = RATE_W'(trial) >= dsr_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[REG_W-2:0], fits};
         rem_in = fits ? REG_W'(RATE_W'(trial) - dsr_ff) : trial[REG_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/vrwr_engine.sv =====
// Slot store, phase counter and the sequencer that serves waits and walks slots on a tick.
module vrwr_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  vrwr_pkg::cfg_type      cfg,
   input  logic                   start,
   input  vrwr_pkg::req_item_type item,
   output logic                   idle,
   output logic                   res_valid,
   output vrwr_pkg::rsp_item_type res,
   input  logic                   res_take
);
   import vrwr_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_WAIT   = 7'b0000010,
      S_TICK   = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_LOAD   = 7'b0010000,
      S_PERIOD = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic                    mod_ff, mod_in;
   req_item_type            item_ff, item_in;
   rsp_item_type            wres_ff, wres_in;
   logic [SLOT_IDX_W-1:0]   slot_ff, slot_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [SLOTS-1:0]        present_ff, present_in;
   logic [RATE_W-1:0]       mem [SLOTS];
   logic [RATE_W-1:0]       rd_data_ff;

   logic                    mem_we;
   logic [SLOT_IDX_W-1:0]   free_idx;
   logic                    free_found;
   logic                    rate_ok;
   logic [HANDLES_W:0]      handles_inc;
   logic [PROD_W-1:0]       product;
   logic [PHASE_W-1:0]      phase_inc;
   logic [PHASE_W-1:0]      phase_new;
   logic                    slot_last;
   logic                    too_fast;
   logic                    release_slot;
   logic                    advance;

   logic                    div_start;
   logic [REG_W-1:0]        div_dividend;
   logic [RATE_W-1:0]       div_divisor;
   logic                    div_busy;
   logic                    div_done;
   logic [REG_W-1:0]        div_quotient;
   logic [REG_W-1:0]        div_remainder;

   vrwr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!present_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      rate_ok = (item_ff.rate_hz >= RATE_MIN) && (item_ff.rate_hz <= RATE_LIMIT) &&
                (item_ff.rate_hz <= cfg.max_rate_hz) &&
                ((item_ff.rate_hz & (item_ff.rate_hz - 1'b1)) == '0);
      handles_inc = {1'b0, item_ff.open_handles} + 1'b1;
      product     = PROD_W'(item_ff.rate_hz) * PROD_W'(handles_inc);
      phase_inc   = phase_ff + 1'b1;
      phase_new   = ({1'b0, phase_inc} >= cfg.base_rate_hz) ? '0 : phase_inc;
      slot_last   = slot_ff == SLOT_IDX_W'(SLOTS - 1);
      too_fast    = rd_data_ff > RATE_W'(cfg.base_rate_hz);
   end

   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      item_in      = item_ff;
      wres_in      = wres_ff;
      slot_in      = slot_ff;
      mask_in      = mask_ff;
      phase_in     = phase_ff;
      present_in   = present_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      div_dividend = cfg.base_rate_hz;
      div_divisor  = rd_data_ff;
      release_slot = 1'b0;
      advance      = 1'b0;
      if (mod_ff) begin
         if (div_done) begin
            mod_in       = 1'b0;
            advance      = 1'b1;
            release_slot = div_remainder == '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  item_in  = item;
                  state_in = (item.kind == KIND_TICK) ? S_TICK : S_WAIT;
               end
            end
            S_WAIT: begin
               wres_in.released_mask = '0;
               wres_in.slot_index    = '0;
               if (!rate_ok) begin
                  wres_in.status = STATUS_BAD_RATE;
               end else if (!free_found) begin
                  wres_in.status = STATUS_FULL;
               end else begin
                  wres_in.status       = STATUS_OK;
                  wres_in.slot_index   = SLOT_OUT_W'(free_idx);
                  present_in[free_idx] = 1'b1;
                  mem_we               = 1'b1;
               end
               state_in = S_DONE;
            end
            S_TICK: begin
               phase_in = phase_new;
               slot_in  = '0;
               mask_in  = '0;
               state_in = S_SCAN;
            end
            S_SCAN: begin
               if (present_ff[slot_ff]) begin
                  state_in = S_LOAD;
               end else begin
                  advance = 1'b1;
               end
            end
            S_LOAD: begin
               if (too_fast) begin
                  release_slot = 1'b1;
                  advance      = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_PERIOD;
               end
            end
            S_PERIOD: begin
               if (div_done) begin
                  div_start    = 1'b1;
                  div_dividend = REG_W'(phase_ff);
                  div_divisor  = RATE_W'(div_quotient);
                  mod_in       = 1'b1;
               end
            end
            S_DONE: begin
               if (res_take) begin
                  state_in = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
      if (release_slot) begin
         present_in[slot_ff] = 1'b0;
         for (int i = 0; i < MASK_W; i++) begin
            if (32'(slot_ff) == 32'(i)) begin
               mask_in[i] = 1'b1;
            end
         end
      end
      if (advance) begin
         if (slot_last) begin
            state_in = S_DONE;
         end else begin
            slot_in  = slot_ff + 1'b1;
            state_in = S_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mod_ff     <= 1'b0;
         phase_ff   <= '0;
         present_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mod_ff     <= mod_in;
         phase_ff   <= phase_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      wres_ff <= wres_in;
      slot_ff <= slot_in;
      mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx] <= product[RATE_W-1:0];
      end
      rd_data_ff <= mem[slot_ff];
   end

   always_comb begin
      idle      = state_ff == S_IDLE;
      res_valid = state_ff == S_DONE;
      if (item_ff.kind == KIND_TICK) begin
         res.status        = STATUS_OK;
         res.slot_index    = '0;
         res.released_mask = mask_ff;
      end else begin
         res = wres_ff;
      end
   end

`ifndef SYNTHESIS
   a_wait_claims_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && rate_ok && free_found) |=> present_ff[$past(free_idx)])
      else $error("granted slot not marked present");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_fast_slot_freed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && !mod_ff && too_fast) |=> !present_ff[$past(slot_ff)])
      else $error("zero-period slot not released");

   a_mod_in_period: assert property (@(posedge clock) disable iff (reset)
      mod_ff |-> (state_ff == S_PERIOD))
      else $error("remainder step outside slot walk");
`endif

endmodule

// ===== rtl/virtual_rate_wait_release_unit.sv =====
// Top level: configuration registers, input handshake and result register.
//
// Waiters share one periodic tick at their own virtual rates. A wait item
// (kind 0) with a valid rate takes the lowest free slot. A tick item
// (kind 1) advances the phase and walks all slots: an empty slot is
// skipped, a slot whose stored rate exceeds the base is released at once,
// and any other present slot waits on a single shared radix-2 divider that
// first forms the period and then the phase remainder. One item is in the
// engine at a time; a finished result sits in an output register so the
// next item can enter while it waits. Slot rates live in a memory with a
// registered read port; rsp_slot_index and rsp_released_mask show slots 0
// to 7 only.
module virtual_rate_wait_release_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [vrwr_pkg::REG_W-1:0]        req_rate_hz,
   input  logic [vrwr_pkg::HANDLES_W-1:0]    req_open_handles,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vrwr_pkg::STATUS_W-1:0]     rsp_status,
   output logic [vrwr_pkg::SLOT_OUT_W-1:0]   rsp_slot_index,
   output logic [vrwr_pkg::MASK_W-1:0]       rsp_released_mask,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vrwr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vrwr_pkg::REG_W-1:0]        csr_data
);
   import vrwr_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   req_item_type req_item;
   rsp_item_type eng_res;
   logic         eng_idle;
   logic         eng_res_valid;
   logic         eng_start;
   logic         res_take;

   assign csr_ready = 1'b1;
   assign req_stall = !eng_idle;
   assign eng_start = req_valid && !req_stall;

   always_comb begin
      req_item.kind         = kind_type'(req_kind);
      req_item.rate_hz      = req_rate_hz;
      req_item.open_handles = req_open_handles;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASE_RATE: cfg_in.base_rate_hz = csr_data;
            CSR_MAX_RATE:  cfg_in.max_rate_hz  = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      res_take     = eng_res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_rate_hz <= BASE_RESET;
         cfg_ff.max_rate_hz  <= MAX_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   vrwr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (eng_start),
      .item      (req_item),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res       (eng_res),
      .res_take  (res_take)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_slot_index    = rsp_ff.slot_index;
   assign rsp_released_mask = rsp_ff.released_mask;

endmodule

// ===== tb/tb_virtual_rate_wait_release_unit.sv =====
// Testbench for the virtual rate wait/release unit: predicts each result and checks it.
module tb_virtual_rate_wait_release_unit;
   import vrwr_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [REG_W-1:0]      req_rate_hz;
   logic [HANDLES_W-1:0]  req_open_handles;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   logic [MASK_W-1:0]     rsp_released_mask;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_data;

   virtual_rate_wait_release_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_rate_hz       (req_rate_hz),
      .req_open_handles  (req_open_handles),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_released_mask (rsp_released_mask),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // predicted block state
   logic [REG_W-1:0]   base_hz = BASE_RESET;
   logic [REG_W-1:0]   max_hz  = MAX_RESET;
   logic [PHASE_W-1:0] phase_now = '0;
   logic               slot_busy [SLOTS];
   logic [RATE_W-1:0]  slot_load [SLOTS];

   rsp_item_type awaited_outcomes [$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int hold_request    = 0;
   int hold_left       = 0;
   int mismatches      = 0;
   int items_sent      = 0;
   int ticks_sent      = 0;
   int results_seen    = 0;
   int grants          = 0;
   int full_rejects    = 0;
   int rate_rejects    = 0;
   int release_ticks   = 0;
   int settings_used   = 1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 5000000);
      $display("FAILURE");
      $finish;
   end

   function automatic int floor_log2(input int unsigned v);
      int r;
      r = 0;
      while ((v >> (r + 1)) != 0) r++;
      return r;
   endfunction

   function automatic rsp_item_type predict_outcome(input req_item_type it);
      rsp_item_type       res;
      int unsigned        period;
      logic [PHASE_W-1:0] step;
      int                 i;
      res.status        = STATUS_OK;
      res.slot_index    = '0;
      res.released_mask = '0;
      if (it.kind == KIND_WAIT) begin
         if (it.rate_hz < RATE_MIN || it.rate_hz > RATE_LIMIT || it.rate_hz > max_hz ||
             (it.rate_hz & (it.rate_hz - 1)) != 0) begin
            res.status = STATUS_BAD_RATE;
            rate_rejects++;
            return res;
         end
         for (i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i]) begin
               slot_busy[i]   = 1'b1;
               slot_load[i]   = RATE_W'(it.rate_hz * (it.open_handles + 1));
               res.slot_index = SLOT_OUT_W'(i);
               grants++;
               return res;
            end
         end
         res.status = STATUS_FULL;
         full_rejects++;
         return res;
      end
      ticks_sent++;
      step = phase_now + 1'b1;
      if (step >= base_hz) step = '0;
      phase_now = step;
      for (i = 0; i < SLOTS; i++) begin
         if (slot_busy[i]) begin
            // stored rate above the base gives a zero period: release at once
            period = (slot_load[i] == 0) ? 0 : base_hz / slot_load[i];
            if (period == 0 || phase_now % period == 0) begin
               slot_busy[i]         = 1'b0;
               res.released_mask[i] = 1'b1;
            end
         end
      end
      if (res.released_mask != 0) release_ticks++;
      return res;
   endfunction

   task automatic send_item(input kind_type k, input logic [REG_W-1:0] r,
                            input logic [HANDLES_W-1:0] h);
      req_item_type it;
      int           gap;
      it.kind         = k;
      it.rate_hz      = r;
      it.open_handles = h;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_rate_hz      <= r;
      req_open_handles <= h;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_outcomes.push_back(predict_outcome(it));
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_BASE_RATE) base_hz = data;
      else if (idx == CSR_MAX_RATE) max_hz = data;
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   task automatic random_item(output req_item_type it);
      int sel;
      int hi;
      int lo;
      it.kind         = KIND_WAIT;
      it.rate_hz      = REG_W'($urandom_range(0, 16383));
      it.open_handles = HANDLES_W'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      hi  = (max_hz >= RATE_LIMIT) ? 13 : floor_log2(max_hz);
      if (sel < 40) begin
         it.kind = KIND_TICK;
      end else if (sel < 54 || max_hz < RATE_MIN) begin
         // noise: mostly malformed rates
      end else if (sel < 58) begin
         it.rate_hz = (hi < 13) ? REG_W'(1 << (hi + 1)) : REG_W'(3 << $urandom_range(0, 12));
      end else begin
         lo = floor_log2(base_hz) - 6;
         if (lo < 1) lo = 1;
         if (lo > hi) lo = hi;
         if ($urandom_range(0, 3) == 0) lo = 1;
         it.rate_hz = REG_W'(1 << $urandom_range(lo, hi));
         if ($urandom_range(0, 9) < 6) it.open_handles = HANDLES_W'($urandom_range(0, 3));
      end
   endtask

   task automatic send_random(input int count);
      req_item_type it;
      repeat (count) begin
         random_item(it);
         send_item(it.kind, it.rate_hz, it.open_handles);
      end
   endtask

   // bad rates, slot allocation up to full, zero-period slot
   task automatic test_request_checks;
      send_item(KIND_WAIT, 14'd0, 8'd0);
      send_item(KIND_WAIT, 14'd1, 8'd0);
      send_item(KIND_WAIT, 14'd3, 8'd0);
      send_item(KIND_WAIT, 14'd2048, 8'd0);
      send_item(KIND_WAIT, 14'h3FFF, 8'hFF);
      send_item(KIND_WAIT, 14'd2, 8'd0);
      send_item(KIND_WAIT, 14'd1024, 8'd0);
      send_item(KIND_WAIT, 14'd1024, 8'd255);
      send_item(KIND_WAIT, 14'd4, 8'd1);
      send_item(KIND_WAIT, 14'd2, 8'd255);
      send_item(KIND_WAIT, 14'd8, 8'd0);
      send_item(KIND_WAIT, 14'd16, 8'd3);
      send_item(KIND_WAIT, 14'd32, 8'd0);
      send_item(KIND_WAIT, 14'd2, 8'd0);
   endtask

   task automatic test_release_ticks;
      repeat (4) send_item(KIND_TICK, 14'h3FFF, 8'hFF);
      send_item(KIND_WAIT, 14'd2, 8'd0);
      send_item(KIND_TICK, 14'd0, 8'd0);
      drain();
   endtask

   // base of 0 and 1 pins the phase at 0
   task automatic test_degenerate_base;
      write_reg(CSR_BASE_RATE, 14'd0);
      write_reg(CSR_MAX_RATE, 14'd8192);
      send_item(KIND_WAIT, 14'd8192, 8'd0);
      send_item(KIND_WAIT, 14'd2, 8'd3);
      send_item(KIND_TICK, 14'd0, 8'd0);
      send_item(KIND_TICK, 14'd0, 8'd0);
      drain();
      write_reg(CSR_BASE_RATE, 14'd1);
      send_item(KIND_WAIT, 14'd2, 8'd0);
      send_item(KIND_TICK, 14'd0, 8'd0);
      drain();
      settings_used += 2;
   endtask

   task automatic test_backpressure;
      write_reg(CSR_BASE_RATE, 14'd64);
      write_reg(CSR_MAX_RATE, 14'd64);
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_request    = 1500;
      send_random(12);
      drain();
      settings_used++;
   endtask

   task automatic test_random_traffic;
      int unsigned bases [6] = '{16, 2, 8192, 64, 16383, 4096};
      int unsigned maxes [6] = '{8192, 2, 8192, 16, 16383, 512};
      int          idles [6] = '{0, 53, 0, 14, 14, 0};
      int          stalls[6] = '{0, 0, 53, 14, 14, 53};
      int          p;
      for (p = 0; p < 6; p++) begin
         write_reg(CSR_BASE_RATE, REG_W'(bases[p]));
         write_reg(CSR_MAX_RATE, REG_W'(maxes[p]));
         sender_idle_pct = idles[p];
         stall_pct       = stalls[p];
         send_random(175);
         drain();
         settings_used++;
      end
      sender_idle_pct = 0;
      stall_pct       = 0;
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type exp;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.status        = status_type'(rsp_status);
         got.slot_index    = rsp_slot_index;
         got.released_mask = rsp_released_mask;
         results_seen++;
         if (awaited_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d slot %0d mask %02h",
                        got.status, got.slot_index, got.released_mask);
         end else begin
            exp = awaited_outcomes.pop_front();
            if (got.status !== exp.status || got.slot_index !== exp.slot_index ||
                got.released_mask !== exp.released_mask) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected status %0d slot %0d mask %02h, got %0d %0d %02h",
                           results_seen, exp.status, exp.slot_index, exp.released_mask,
                           got.status, got.slot_index, got.released_mask);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_load[i] = '0;
      end
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_WAIT;
      req_rate_hz      <= '0;
      req_open_handles <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_BASE_RATE;
      csr_data         <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_request_checks();
      test_release_ticks();
      test_degenerate_base();
      test_backpressure();
      test_random_traffic();
      drain();
      repeat (300) @(posedge clock);
      $display("Ran %0d items (%0d ticks) over %0d register settings; %0d results checked.",
               items_sent, ticks_sent, settings_used, results_seen);
      $display("Slots granted %0d, full %0d, bad rate %0d, ticks releasing slots %0d.",
               grants, full_rejects, rate_rejects, release_ticks);
      if (mismatches == 0 && awaited_outcomes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/vrwr_pkg.sv
rtl/vrwr_div.sv
rtl/vrwr_engine.sv
rtl/virtual_rate_wait_release_unit.sv
tb/tb_virtual_rate_wait_release_unit.sv
